### sv/sfse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfse_pkg: shared types, codes and tables of the soft forward splat engine
// Operation and register codes, controller/datapath interface structs and
// the exponential and preference lookup tables.
// ----------------------------------------------------------------------------
package sfse_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 7;
  localparam int DEF_FRAC_BITS  = 8;

  localparam logic [1:0] OP_SPLAT = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_FIELD_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FIELD_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS       = 2'd2;
  localparam logic [1:0] CFG_KERNEL_SCALE = 2'd3;

  localparam logic [14:0] STEEP_Q16 = 15'd21627;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic next_cell;
    logic clr_step;
    logic resp;
  } sfse_cmd_t;

  typedef struct packed {
    logic inb;
    logic last_cell;
    logic clr_last;
  } sfse_sts_t;

  function automatic logic [16:0] exp_int(input logic [3:0] n);
    case (n)
      4'd0:    return 17'd65536;
      4'd1:    return 17'd24109;
      4'd2:    return 17'd8869;
      4'd3:    return 17'd3263;
      4'd4:    return 17'd1200;
      4'd5:    return 17'd442;
      4'd6:    return 17'd162;
      4'd7:    return 17'd60;
      4'd8:    return 17'd22;
      4'd9:    return 17'd8;
      4'd10:   return 17'd3;
      4'd11:   return 17'd1;
      default: return 17'd0;
    endcase
  endfunction

  function automatic logic [16:0] exp_frac(input logic [3:0] f);
    case (f)
      4'd0:    return 17'd65536;
      4'd1:    return 17'd61565;
      4'd2:    return 17'd57835;
      4'd3:    return 17'd54331;
      4'd4:    return 17'd51039;
      4'd5:    return 17'd47947;
      4'd6:    return 17'd45042;
      4'd7:    return 17'd42313;
      4'd8:    return 17'd39750;
      4'd9:    return 17'd37341;
      4'd10:   return 17'd35079;
      4'd11:   return 17'd32954;
      4'd12:   return 17'd30957;
      4'd13:   return 17'd29081;
      4'd14:   return 17'd27320;
      default: return 17'd25664;
    endcase
  endfunction

  function automatic logic [16:0] pref_tab(input logic [4:0] k);
    case (k)
      5'd0:    return 17'd32768;
      5'd1:    return 17'd40794;
      5'd2:    return 17'd47911;
      5'd3:    return 17'd53581;
      5'd4:    return 17'd57724;
      5'd5:    return 17'd60565;
      5'd6:    return 17'd62428;
      5'd7:    return 17'd63615;
      5'd8:    return 17'd64357;
      5'd9:    return 17'd64816;
      5'd10:   return 17'd65097;
      5'd11:   return 17'd65268;
      5'd12:   return 17'd65374;
      5'd13:   return 17'd65438;
      5'd14:   return 17'd65476;
      5'd15:   return 17'd65500;
      default: return 17'd65514;
    endcase
  endfunction

endpackage
`default_nettype wire

### sv/sfse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfse_ctrl: controller of the soft forward splat engine
// Sequences the clearing pass, the per-cell read-modify-write of a splat,
// the single-cell read and the result strobe.
// ----------------------------------------------------------------------------
module sfse_ctrl
  import sfse_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [1:0] op_i,
  input  wire sfse_sts_t  sts_i,
  output sfse_cmd_t       cmd_o,
  output logic            busy
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ADDR, ST_RD, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
    ST_WR, ST_READ, ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   clr_resp_q, clr_resp_d;

  always_comb begin
    state_d    = state_q;
    clr_resp_d = clr_resp_q;
    cmd_o      = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d    = clr_resp_q ? ST_RESP : ST_IDLE;
          clr_resp_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (op_i)
            OP_SPLAT: state_d = ST_ADDR;
            OP_CLEAR: begin
              state_d    = ST_CLEAR;
              clr_resp_d = 1'b1;
            end
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_RESP;
          endcase
        end
      end
      ST_ADDR: begin
        // skip cells outside the field without a store access
        if (sts_i.inb) begin
          state_d = ST_RD;
        end else begin
          cmd_o.next_cell = 1'b1;
          state_d = sts_i.last_cell ? ST_RESP : ST_ADDR;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_M1;
      end
      ST_M1: state_d = ST_M2;
      ST_M2: state_d = ST_M3;
      ST_M3: state_d = ST_M4;
      ST_M4: state_d = ST_M5;
      ST_M5: state_d = ST_WR;
      ST_WR: begin
        cmd_o.wr        = 1'b1;
        cmd_o.next_cell = 1'b1;
        state_d = sts_i.last_cell ? ST_RESP : ST_ADDR;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.resp = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_resp_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_resp_q <= clr_resp_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

### sv/sfse_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfse_dp: datapath of the soft forward splat engine
// Configuration registers, cell counters, the cell store and the staged
// kernel, preference and blend arithmetic.
// ----------------------------------------------------------------------------
module sfse_dp
  import sfse_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [19:0] pos_x_i,
  input  wire logic signed [19:0] pos_y_i,
  input  wire logic signed [19:0] value_x_i,
  input  wire logic signed [19:0] value_y_i,
  input  wire logic [7:0]         read_col_i,
  input  wire logic [7:0]         read_row_i,
  input  wire sfse_cmd_t          cmd_i,
  output sfse_sts_t               sts_o,
  output logic                    done_o,
  output logic signed [19:0]      cell_x_o,
  output logic signed [19:0]      cell_y_o,
  output logic [16:0]             cell_weight_o
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int WEW   = $clog2(MAX_WIDTH + 1);
  localparam int HEW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int IW    = RW + 1;
  localparam int XW    = 22 - FRAC_BITS;
  localparam int CW    = XW + WEW + HEW;
  localparam int DW    = $clog2((MAX_RADIUS + 1) << FRAC_BITS) + 2;
  localparam int D2W   = 2 * DW;
  localparam int EPW   = 17 + D2W;
  localparam int ESH   = 8 + 2 * FRAC_BITS;
  localparam int EW    = EPW - ESH;
  localparam int PSH   = 2 * FRAC_BITS + 14;
  localparam longint LIM = ((longint'(17) << PSH) + 21626) / 21627;
  localparam int MW    = $clog2(LIM);
  localparam int KMW   = MW + 15;

  // configuration
  logic [8:0]  fw_q, fh_q;
  logic [2:0]  rad_q;
  logic [15:0] ks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 9'd256;
      fh_q  <= 9'd256;
      rad_q <= 3'd3;
      ks_q  <= 16'd3641;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIELD_WIDTH:  fw_q  <= cfg_wdata_i[8:0];
        CFG_FIELD_HEIGHT: fh_q  <= cfg_wdata_i[8:0];
        CFG_RADIUS:       rad_q <= cfg_wdata_i[2:0];
        CFG_KERNEL_SCALE: ks_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [RW-1:0]  r_eff;
  assign w_eff = (fw_q > MAX_WIDTH)  ? WEW'(MAX_WIDTH)  : WEW'(fw_q);
  assign h_eff = (fh_q > MAX_HEIGHT) ? HEW'(MAX_HEIGHT) : HEW'(fh_q);
  assign r_eff = (rad_q > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_q);

  // item registers
  logic [1:0]           op_q;
  logic signed [19:0]   px_q, py_q, vx_q, vy_q;
  logic [7:0]           rcol_q, rrow_q;
  logic signed [XW-1:0] ix_q, iy_q;
  logic signed [20:0]   pxa, pya;
  logic [20:0]          pxt, pyt;

  // truncate toward zero: shift the magnitude, restore the sign
  assign pxa = pos_x_i[19] ? -{pos_x_i[19], pos_x_i} : {pos_x_i[19], pos_x_i};
  assign pya = pos_y_i[19] ? -{pos_y_i[19], pos_y_i} : {pos_y_i[19], pos_y_i};
  assign pxt = pos_x_i[19] ? -(21'(pxa) >> FRAC_BITS) : (21'(pxa) >> FRAC_BITS);
  assign pyt = pos_y_i[19] ? -(21'(pya) >> FRAC_BITS) : (21'(pya) >> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      vx_q   <= value_x_i;
      vy_q   <= value_y_i;
      rcol_q <= read_col_i;
      rrow_q <= read_row_i;
      ix_q   <= $signed(pxt[XW-1:0]);
      iy_q   <= $signed(pyt[XW-1:0]);
    end
  end

  // neighborhood counters
  logic signed [IW-1:0] ci_q, cj_q, r_s;
  assign r_s = $signed({1'b0, r_eff});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q <= '0;
      cj_q <= '0;
    end else if (cmd_i.load) begin
      ci_q <= -r_s;
      cj_q <= -r_s;
    end else if (cmd_i.next_cell) begin
      if (cj_q == r_s) begin
        cj_q <= -r_s;
        ci_q <= ci_q + IW'(1);
      end else begin
        cj_q <= cj_q + IW'(1);
      end
    end
  end

  logic signed [XW-1:0] cx, cy;
  logic                 inb;
  logic [AW-1:0]        cell_addr, read_addr;
  logic                 rinb;

  assign cx  = ix_q + {{(XW-IW){ci_q[IW-1]}}, ci_q};
  assign cy  = iy_q + {{(XW-IW){cj_q[IW-1]}}, cj_q};
  assign inb = !cx[XW-1] && !cy[XW-1] &&
               (CW'($unsigned(cx)) < CW'(w_eff)) && (CW'($unsigned(cy)) < CW'(h_eff));
  assign cell_addr = AW'(AW'($unsigned(cy)) * AW'(MAX_WIDTH)) + AW'($unsigned(cx));
  assign rinb = (CW'(rcol_q) < CW'(w_eff)) && (CW'(rrow_q) < CW'(h_eff));
  assign read_addr = AW'(AW'(rrow_q) * AW'(MAX_WIDTH)) + AW'(rcol_q);

  // clearing pass counter
  logic [AW-1:0] clr_q;
  logic          clr_last;
  assign clr_last = (clr_q == AW'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_last ? '0 : clr_q + AW'(1);
    end
  end

  assign sts_o.inb       = inb;
  assign sts_o.last_cell = (ci_q == r_s) && (cj_q == r_s);
  assign sts_o.clr_last  = clr_last;

  // cell store: displacement x, displacement y, weight
  logic [56:0]   store_q [CELLS];
  logic [56:0]   rdata_q;
  logic [56:0]   wdata;
  logic [AW-1:0] waddr, raddr;
  logic          we;

  assign raddr = (op_q == OP_READ) ? read_addr : cell_addr;
  assign waddr = cmd_i.clr_step ? clr_q : cell_addr;
  assign we    = cmd_i.clr_step | cmd_i.wr;

  always_ff @(posedge clk_i) begin
    if (we) store_q[waddr] <= wdata;
    if (cmd_i.rd) rdata_q <= store_q[raddr];
  end

  logic signed [19:0] sx, sy;
  logic [16:0]        sw;
  assign sx = $signed(rdata_q[56:37]);
  assign sy = $signed(rdata_q[36:17]);
  assign sw = rdata_q[16:0];

  // kernel chain: counters hold still during a cell, so the stages run free
  logic signed [31:0]    dx32, dy32;
  logic signed [D2W-1:0] dxe, dye;
  logic [D2W-1:0]        dx2_q, dy2_q;
  logic [D2W:0]          d2_q;
  logic [EPW-1:0]        ep;
  logic [EW-1:0]         e_q;
  logic                  bige_q;
  logic [33:0]           kprod_q;
  logic [16:0]           kern;

  assign dx32 = (32'(cx) <<< FRAC_BITS) - 32'(px_q);
  assign dy32 = (32'(cy) <<< FRAC_BITS) - 32'(py_q);
  assign dxe  = D2W'($signed(dx32[DW-1:0]));
  assign dye  = D2W'($signed(dy32[DW-1:0]));
  assign ep   = EPW'(ks_q) * EPW'(d2_q);
  assign kern = bige_q ? 17'd0 : 17'((kprod_q + 34'd32768) >> 16);

  always_ff @(posedge clk_i) begin
    dx2_q   <= $unsigned(dxe * dxe);
    dy2_q   <= $unsigned(dye * dye);
    d2_q    <= (D2W+1)'(dx2_q) + (D2W+1)'(dy2_q);
    e_q     <= EW'(ep >> ESH);
    bige_q  <= (e_q >= EW'(192));
    kprod_q <= 34'(exp_int(e_q[7:4])) * 34'(exp_frac(e_q[3:0]));
  end

  // preference chain
  logic signed [39:0] vx2_q, vy2_q, sx2_q, sy2_q;
  logic [40:0]        mag1, mag0;
  logic signed [41:0] diff;
  logic [40:0]        m_q;
  logic               neg_q, neg2_q, bigm_q;
  logic [KMW-1:0]     km_q, kraw;
  logic [4:0]         k;
  logic [16:0]        pref;
  logic [33:0]        wprod_q;

  assign mag1 = 41'($unsigned(vx2_q)) + 41'($unsigned(vy2_q));
  assign mag0 = 41'($unsigned(sx2_q)) + 41'($unsigned(sy2_q));
  assign diff = $signed({1'b0, mag1}) - $signed({1'b0, mag0});
  assign kraw = km_q >> PSH;
  assign k    = (bigm_q || (kraw > KMW'(16))) ? 5'd16 : kraw[4:0];
  assign pref = neg2_q ? (ONE_Q16 - pref_tab(k)) : pref_tab(k);

  always_ff @(posedge clk_i) begin
    vx2_q   <= 40'(vx_q) * 40'(vx_q);
    vy2_q   <= 40'(vy_q) * 40'(vy_q);
    sx2_q   <= 40'(sx) * 40'(sx);
    sy2_q   <= 40'(sy) * 40'(sy);
    neg_q   <= diff[41];
    m_q     <= diff[41] ? 41'($unsigned(-diff)) : 41'($unsigned(diff));
    bigm_q  <= (m_q >= LIM);
    neg2_q  <= neg_q;
    km_q    <= KMW'(m_q[MW-1:0]) * KMW'(STEEP_Q16);
    wprod_q <= 34'(pref) * 34'(kern);
  end

  // blend chain
  logic [16:0]        w, wc;
  logic signed [38:0] bx_q, by_q;
  logic [17:0]        nw;
  logic [16:0]        nw_q;
  logic signed [38:0] bxr, byr;

  assign w   = 17'((wprod_q + 34'd32768) >> 16);
  assign wc  = ONE_Q16 - w;
  assign nw  = 18'(sw) + 18'(w);
  assign bxr = (bx_q + 39'sd32768) >>> 16;
  assign byr = (by_q + 39'sd32768) >>> 16;

  always_ff @(posedge clk_i) begin
    bx_q <= 39'(vx_q) * $signed({22'd0, w}) + 39'(sx) * $signed({22'd0, wc});
    by_q <= 39'(vy_q) * $signed({22'd0, w}) + 39'(sy) * $signed({22'd0, wc});
    nw_q <= (nw > 18'(ONE_Q16)) ? ONE_Q16 : nw[16:0];
  end

  assign wdata = cmd_i.clr_step ? 57'd0 : {bxr[19:0], byr[19:0], nw_q};

  // result registers
  logic               done_q;
  logic signed [19:0] ox_q, oy_q;
  logic [16:0]        ow_q;
  logic               hit;
  assign hit = (op_q == OP_READ) && rinb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.resp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      ox_q <= hit ? sx : 20'sd0;
      oy_q <= hit ? sy : 20'sd0;
      ow_q <= hit ? sw : 17'd0;
    end
  end

  assign done_o        = done_q;
  assign cell_x_o      = ox_q;
  assign cell_y_o      = oy_q;
  assign cell_weight_o = ow_q;

endmodule
`default_nettype wire

### sv/soft_forward_splat_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// soft_forward_splat_engine_core: Gaussian forward splatting engine
// Splats weighted displacement values into a cell store, reads and clears it.
// ----------------------------------------------------------------------------
// Raise start for a cycle while busy is low to issue an item; its one result
// appears with done_o for exactly one cycle and must be taken then, as the
// block cannot be stalled. All work goes through the cell store, which has one
// write and one read port: a splat reads, blends and writes back each in-field
// cell of the neighborhood and skips each cell outside the field, a read
// fetches one cell, and a clear zeroes every cell. After reset busy stays high
// for a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells; configuration
// writes are taken at any time but belong in idle periods.
module soft_forward_splat_engine_core
  import sfse_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [19:0] pos_x_i,
  input  wire logic signed [19:0] pos_y_i,
  input  wire logic signed [19:0] value_x_i,
  input  wire logic signed [19:0] value_y_i,
  input  wire logic [7:0]         read_col_i,
  input  wire logic [7:0]         read_row_i,
  output logic                    done_o,
  output logic signed [19:0]      cell_x_o,
  output logic signed [19:0]      cell_y_o,
  output logic [16:0]             cell_weight_o
);

  sfse_cmd_t cmd;
  sfse_sts_t sts;

  sfse_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sfse_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .value_x_i     (value_x_i),
    .value_y_i     (value_y_i),
    .read_col_i    (read_col_i),
    .read_row_i    (read_row_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done_o),
    .cell_x_o      (cell_x_o),
    .cell_y_o      (cell_y_o),
    .cell_weight_o (cell_weight_o)
  );

  // a transfer in always leaves the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without prior work");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cell_weight_o <= 17'd65536)) else $error("weight above one");

endmodule
`default_nettype wire
